FILE: rtl/ihex_pkg.sv
package ihex_pkg;

  localparam int MAX_LEN = 16;
  localparam int IDX_W   = $clog2(MAX_LEN);

  localparam logic [7:0] COLON = 8'h3A;

  typedef enum logic [2:0] {
    PH_WAIT,
    PH_LEN,
    PH_ADDR,
    PH_TYPE,
    PH_DATA,
    PH_CSUM,
    PH_EMIT,
    PH_STOP
  } phase_t;

  typedef enum logic [2:0] {
    ST_DATA  = 3'd0,
    ST_EMPTY = 3'd1,
    ST_TYPE  = 3'd2,
    ST_START = 3'd3,
    ST_DIGIT = 3'd4,
    ST_LONG  = 3'd5,
    ST_CSUM  = 3'd6
  } status_t;

  typedef struct packed {
    logic    clr_rec;
    logic    take;
    logic    ld_len;
    logic    ld_addr;
    logic    ld_type;
    logic    ld_data;
    logic    clr_dc;
    logic    out_ld;
    status_t out_st;
    logic    emit;
  } cmd_t;

  typedef struct packed {
    logic is_space;
    logic is_hex;
    logic is_colon;
    logic odd;
    logic dc_zero;
    logic addr_done;
    logic data_done;
    logic len_zero;
    logic len_long;
    logic sum_zero;
    logic type_zero;
    logic emit_last;
    logic out_free;
  } sts_t;

endpackage

FILE: rtl/intel_hex_record_parser.sv
// channel   direction  handshake           payload
// in_       input      in_valid/in_stall   char_byte[7:0], restart
// out_      output     out_valid/out_stall status[2:0], record_address[15:0], byte_index[3:0],
//                                          data_byte[7:0], record_type[7:0],
//                                          record_length[7:0], last
//
// One character transaction per cycle while no result burst is pending and the output is free.
// A passing data record drains one result per cycle while the output is not stalled,
// length results in all, from the record buffer; input stalls for that burst.
// Synchronous active-low reset returns to waiting for a colon, output empty.
// A stalled output holds its result and stalls the input behind it.
module intel_hex_record_parser (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_char_byte,
  input  logic        in_restart,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [2:0]  out_status,
  output logic [15:0] out_record_address,
  output logic [3:0]  out_byte_index,
  output logic [7:0]  out_data_byte,
  output logic [7:0]  out_record_type,
  output logic [7:0]  out_record_length,
  output logic        out_last
);

  ihex_pkg::cmd_t cmd;
  ihex_pkg::sts_t sts;

  ihex_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_restart (in_restart),
    .in_stall   (in_stall),
    .sts        (sts),
    .cmd        (cmd)
  );

  ihex_dp u_dp (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_char_byte       (in_char_byte),
    .cmd                (cmd),
    .sts                (sts),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_status         (out_status),
    .out_record_address (out_record_address),
    .out_byte_index     (out_byte_index),
    .out_data_byte      (out_data_byte),
    .out_record_type    (out_record_type),
    .out_record_length  (out_record_length),
    .out_last           (out_last)
  );

  a_status_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status != ihex_pkg::ST_DATA) |-> out_last)
    else $error("status result without last");

  a_status_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status != ihex_pkg::ST_DATA) |->
      (out_data_byte == 8'd0) && (out_byte_index == 4'd0))
    else $error("status result carries data");

  a_last_index: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_last && (out_status == ihex_pkg::ST_DATA) |->
      ({4'd0, out_byte_index} == out_record_length - 8'd1))
    else $error("last data byte index mismatch");

  a_burst_stall: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_stall && !out_last |=>
      out_valid && (out_status == ihex_pkg::ST_DATA))
    else $error("data burst interrupted");

endmodule

FILE: rtl/ihex_ctrl.sv
module ihex_ctrl (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  input  logic            in_restart,
  output logic            in_stall,
  input  ihex_pkg::sts_t  sts,
  output ihex_pkg::cmd_t  cmd
);

  ihex_pkg::phase_t state_r, state_nxt;
  logic acc;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ihex_pkg::PH_WAIT;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign in_stall = (state_r == ihex_pkg::PH_EMIT) || !sts.out_free;
  assign acc      = in_valid && !in_stall;

  always_comb begin
    state_nxt  = state_r;
    cmd        = '0;
    cmd.out_st = ihex_pkg::ST_DATA;
    if (state_r == ihex_pkg::PH_EMIT) begin
      if (sts.out_free) begin
        cmd.emit = 1'b1;
        if (sts.emit_last) begin
          cmd.clr_rec = 1'b1;
          state_nxt   = ihex_pkg::PH_WAIT;
        end
      end
    end else if (acc) begin
      if (in_restart) begin
        cmd.clr_rec = 1'b1;
        state_nxt   = ihex_pkg::PH_WAIT;
      end else begin
        case (state_r)
          ihex_pkg::PH_STOP: begin
          end
          ihex_pkg::PH_WAIT: begin
            if (sts.is_colon) begin
              cmd.clr_rec = 1'b1;
              state_nxt   = ihex_pkg::PH_LEN;
            end else if (!sts.is_space) begin
              cmd.out_ld  = 1'b1;
              cmd.out_st  = ihex_pkg::ST_START;
              cmd.clr_rec = 1'b1;
              state_nxt   = ihex_pkg::PH_STOP;
            end
          end
          default: begin
            if (sts.is_space) begin
              if ((state_r == ihex_pkg::PH_DATA) ? sts.odd : !sts.dc_zero) begin
                cmd.out_ld  = 1'b1;
                cmd.out_st  = ihex_pkg::ST_DIGIT;
                cmd.clr_rec = 1'b1;
                state_nxt   = ihex_pkg::PH_STOP;
              end
            end else if (!sts.is_hex) begin
              cmd.out_ld  = 1'b1;
              cmd.out_st  = ihex_pkg::ST_DIGIT;
              cmd.clr_rec = 1'b1;
              state_nxt   = ihex_pkg::PH_STOP;
            end else begin
              cmd.take = 1'b1;
              if (sts.odd) begin
                case (state_r)
                  ihex_pkg::PH_LEN: begin
                    cmd.ld_len = 1'b1;
                    cmd.clr_dc = 1'b1;
                    state_nxt  = ihex_pkg::PH_ADDR;
                  end
                  ihex_pkg::PH_ADDR: begin
                    cmd.ld_addr = 1'b1;
                    if (sts.addr_done) begin
                      cmd.clr_dc = 1'b1;
                      state_nxt  = ihex_pkg::PH_TYPE;
                    end
                  end
                  ihex_pkg::PH_TYPE: begin
                    cmd.ld_type = 1'b1;
                    cmd.clr_dc  = 1'b1;
                    if (sts.len_long) begin
                      cmd.out_ld  = 1'b1;
                      cmd.out_st  = ihex_pkg::ST_LONG;
                      cmd.clr_rec = 1'b1;
                      state_nxt   = ihex_pkg::PH_STOP;
                    end else begin
                      state_nxt = sts.len_zero ? ihex_pkg::PH_CSUM : ihex_pkg::PH_DATA;
                    end
                  end
                  ihex_pkg::PH_DATA: begin
                    cmd.ld_data = 1'b1;
                    if (sts.data_done) begin
                      cmd.clr_dc = 1'b1;
                      state_nxt  = ihex_pkg::PH_CSUM;
                    end
                  end
                  ihex_pkg::PH_CSUM: begin
                    cmd.clr_dc = 1'b1;
                    if (!sts.sum_zero) begin
                      cmd.out_ld  = 1'b1;
                      cmd.out_st  = ihex_pkg::ST_CSUM;
                      cmd.clr_rec = 1'b1;
                      state_nxt   = ihex_pkg::PH_STOP;
                    end else if (!sts.type_zero) begin
                      cmd.out_ld  = 1'b1;
                      cmd.out_st  = ihex_pkg::ST_TYPE;
                      cmd.clr_rec = 1'b1;
                      state_nxt   = ihex_pkg::PH_STOP;
                    end else if (sts.len_zero) begin
                      cmd.out_ld  = 1'b1;
                      cmd.out_st  = ihex_pkg::ST_EMPTY;
                      cmd.clr_rec = 1'b1;
                      state_nxt   = ihex_pkg::PH_WAIT;
                    end else begin
                      state_nxt = ihex_pkg::PH_EMIT;
                    end
                  end
                  default: begin
                  end
                endcase
              end
            end
          end
        endcase
      end
    end
  end

endmodule

FILE: rtl/ihex_dp.sv
module ihex_dp (
  input  logic            clk,
  input  logic            rst_n,
  input  logic [7:0]      in_char_byte,
  input  ihex_pkg::cmd_t  cmd,
  output ihex_pkg::sts_t  sts,
  output logic            out_valid,
  input  logic            out_stall,
  output logic [2:0]      out_status,
  output logic [15:0]     out_record_address,
  output logic [3:0]      out_byte_index,
  output logic [7:0]      out_data_byte,
  output logic [7:0]      out_record_type,
  output logic [7:0]      out_record_length,
  output logic            out_last
);

  logic [5:0]  dc_r;
  logic [3:0]  hi_r;
  logic [7:0]  len_r;
  logic [15:0] addr_r;
  logic [7:0]  type_r;
  logic [7:0]  sum_r;
  logic [ihex_pkg::IDX_W-1:0] emit_idx_r;
  logic [7:0]  store_r [ihex_pkg::MAX_LEN];

  logic        out_valid_r;
  logic [2:0]  out_status_r;
  logic [15:0] out_addr_r;
  logic [3:0]  out_idx_r;
  logic [7:0]  out_data_r;
  logic [7:0]  out_type_r;
  logic [7:0]  out_len_r;
  logic        out_last_r;

  logic [3:0]  nib;
  logic        hex_ok;
  logic [7:0]  byte_val;
  logic [7:0]  sum_nxt;
  logic [8:0]  dc_ext;
  logic [7:0]  type_out;

  always_comb begin
    nib    = 4'd0;
    hex_ok = 1'b1;
    if (in_char_byte inside {[8'h30:8'h39]}) begin
      nib = in_char_byte[3:0];
    end else if (in_char_byte inside {[8'h41:8'h46], [8'h61:8'h66]}) begin
      nib = in_char_byte[3:0] + 4'd9;
    end else begin
      hex_ok = 1'b0;
    end
  end

  assign byte_val = {hi_r, nib};
  assign sum_nxt  = sum_r + byte_val;
  assign dc_ext   = {3'b000, dc_r} + 9'd1;
  assign type_out = (cmd.take && cmd.ld_type) ? byte_val : type_r;

  assign sts.is_space  = (in_char_byte == 8'h20) || (in_char_byte inside {[8'h09:8'h0D]});
  assign sts.is_hex    = hex_ok;
  assign sts.is_colon  = (in_char_byte == ihex_pkg::COLON);
  assign sts.odd       = dc_r[0];
  assign sts.dc_zero   = (dc_r == 6'd0);
  assign sts.addr_done = (dc_r == 6'd3);
  assign sts.data_done = (dc_ext >= {len_r, 1'b0});
  assign sts.len_zero  = (len_r == 8'd0);
  assign sts.len_long  = (len_r > 8'(ihex_pkg::MAX_LEN));
  assign sts.sum_zero  = (sum_nxt == 8'd0);
  assign sts.type_zero = (type_r == 8'd0);
  assign sts.emit_last = (emit_idx_r == ihex_pkg::IDX_W'(len_r - 8'd1));
  assign sts.out_free  = !out_valid_r || !out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n || cmd.clr_rec) begin
      dc_r       <= '0;
      hi_r       <= '0;
      len_r      <= '0;
      addr_r     <= '0;
      type_r     <= '0;
      sum_r      <= '0;
      emit_idx_r <= '0;
    end else begin
      if (cmd.take) begin
        if (!dc_r[0]) begin
          hi_r <= nib;
        end else begin
          sum_r <= sum_nxt;
          if (cmd.ld_len) begin
            len_r <= byte_val;
          end
          if (cmd.ld_addr) begin
            addr_r <= {addr_r[7:0], byte_val};
          end
          if (cmd.ld_type) begin
            type_r <= byte_val;
          end
        end
        dc_r <= cmd.clr_dc ? 6'd0 : dc_r + 6'd1;
      end
      if (cmd.emit) begin
        emit_idx_r <= emit_idx_r + ihex_pkg::IDX_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.take && cmd.ld_data && dc_r[0] && !dc_r[5]) begin
      store_r[dc_r[ihex_pkg::IDX_W:1]] <= byte_val;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_ld || cmd.emit) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_ld) begin
      out_status_r <= cmd.out_st;
      out_addr_r   <= addr_r;
      out_idx_r    <= '0;
      out_data_r   <= '0;
      out_type_r   <= type_out;
      out_len_r    <= len_r;
      out_last_r   <= 1'b1;
    end else if (cmd.emit) begin
      out_status_r <= ihex_pkg::ST_DATA;
      out_addr_r   <= addr_r;
      out_idx_r    <= 4'(emit_idx_r);
      out_data_r   <= store_r[emit_idx_r];
      out_type_r   <= type_r;
      out_len_r    <= len_r;
      out_last_r   <= sts.emit_last;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_status         = out_status_r;
  assign out_record_address = out_addr_r;
  assign out_byte_index     = out_idx_r;
  assign out_data_byte      = out_data_r;
  assign out_record_type    = out_type_r;
  assign out_record_length  = out_len_r;
  assign out_last           = out_last_r;

endmodule

FILE: tb/intel_hex_record_parser_tb.sv
module intel_hex_record_parser_tb;

  typedef struct packed {
    logic [7:0] ch;
    logic       rs;
  } hex_char_t;

  typedef struct {
    ihex_pkg::status_t st;
    logic [15:0] addr;
    logic [3:0]  idx;
    logic [7:0]  data;
    logic [7:0]  rtype;
    logic [7:0]  rlen;
    logic        last;
  } hex_result_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [7:0]  in_char_byte = 8'h00;
  logic        in_restart = 1'b0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [2:0]  out_status;
  logic [15:0] out_record_address;
  logic [3:0]  out_byte_index;
  logic [7:0]  out_data_byte;
  logic [7:0]  out_record_type;
  logic [7:0]  out_record_length;
  logic        out_last;

  hex_char_t   pending_chars[$];
  hex_result_t expected_results[$];
  hex_char_t   next_char;
  int          mismatches = 0;
  int          send_idle_pct = 0;
  int          stall_pct = 0;
  logic        hold_go = 1'b0;
  logic        hold_done = 1'b0;
  int          hold_left = 0;

  ihex_pkg::phase_t rec_phase;
  int          digit_cnt;
  logic [3:0]  hi_nib;
  logic [7:0]  rec_len;
  logic [15:0] rec_addr;
  logic [7:0]  rec_type;
  logic [7:0]  rec_sum;
  logic [7:0]  rec_bytes[ihex_pkg::MAX_LEN];
  logic        halted;

  intel_hex_record_parser dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_char_byte(in_char_byte),
    .in_restart(in_restart),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_status(out_status),
    .out_record_address(out_record_address),
    .out_byte_index(out_byte_index),
    .out_data_byte(out_data_byte),
    .out_record_type(out_record_type),
    .out_record_length(out_record_length),
    .out_last(out_last)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  function automatic logic is_blank(logic [7:0] c);
    return c == " " || (c >= 8'h09 && c <= 8'h0D);
  endfunction

  function automatic int nibble_of(logic [7:0] c);
    if (c >= "0" && c <= "9") return c - "0";
    if (c >= "A" && c <= "F") return c - "A" + 10;
    if (c >= "a" && c <= "f") return c - "a" + 10;
    return -1;
  endfunction

  task automatic clear_record();
    rec_phase = ihex_pkg::PH_WAIT;
    digit_cnt = 0;
    hi_nib = '0;
    rec_len = '0;
    rec_addr = '0;
    rec_type = '0;
    rec_sum = '0;
  endtask

  task automatic finish_record(ihex_pkg::status_t st);
    expected_results.push_back('{st, rec_addr, 4'd0, 8'd0, rec_type, rec_len, 1'b1});
    if (st != ihex_pkg::ST_EMPTY) halted = 1'b1;
    clear_record();
  endtask

  task automatic close_record();
    if (rec_sum != 0) begin
      finish_record(ihex_pkg::ST_CSUM);
    end else if (rec_type != 0) begin
      finish_record(ihex_pkg::ST_TYPE);
    end else if (rec_len == 0) begin
      finish_record(ihex_pkg::ST_EMPTY);
    end else begin
      for (int k = 0; k < rec_len; k++)
        expected_results.push_back('{ihex_pkg::ST_DATA, rec_addr, k[3:0], rec_bytes[k],
                                     rec_type, rec_len, k == rec_len - 1});
      clear_record();
    end
  endtask

  task automatic parse_char(logic [7:0] c, logic rs);
    int         nib;
    logic [7:0] b;
    if (rs) begin
      halted = 1'b0;
      clear_record();
      return;
    end
    if (halted) return;
    if (rec_phase == ihex_pkg::PH_WAIT) begin
      if (is_blank(c)) return;
      if (c != ihex_pkg::COLON) begin
        finish_record(ihex_pkg::ST_START);
        return;
      end
      clear_record();
      rec_phase = ihex_pkg::PH_LEN;
      return;
    end
    if (is_blank(c)) begin
      if ((rec_phase == ihex_pkg::PH_DATA) ? digit_cnt[0] : (digit_cnt != 0))
        finish_record(ihex_pkg::ST_DIGIT);
      return;
    end
    nib = nibble_of(c);
    if (nib < 0) begin
      finish_record(ihex_pkg::ST_DIGIT);
      return;
    end
    if (!digit_cnt[0]) begin
      hi_nib = nib[3:0];
      digit_cnt++;
      return;
    end
    b = {hi_nib, nib[3:0]};
    digit_cnt++;
    rec_sum = rec_sum + b;
    case (rec_phase)
      ihex_pkg::PH_LEN: begin
        rec_len = b;
        rec_phase = ihex_pkg::PH_ADDR;
        digit_cnt = 0;
      end
      ihex_pkg::PH_ADDR: begin
        rec_addr = {rec_addr[7:0], b};
        if (digit_cnt >= 4) begin
          rec_phase = ihex_pkg::PH_TYPE;
          digit_cnt = 0;
        end
      end
      ihex_pkg::PH_TYPE: begin
        rec_type = b;
        digit_cnt = 0;
        if (rec_len > ihex_pkg::MAX_LEN) finish_record(ihex_pkg::ST_LONG);
        else rec_phase = (rec_len == 0) ? ihex_pkg::PH_CSUM : ihex_pkg::PH_DATA;
      end
      ihex_pkg::PH_DATA: begin
        rec_bytes[digit_cnt / 2 - 1] = b;
        if (digit_cnt >= 2 * rec_len) begin
          rec_phase = ihex_pkg::PH_CSUM;
          digit_cnt = 0;
        end
      end
      default: close_record();
    endcase
  endtask

  task automatic report_mismatch(string msg);
    $display("mismatch: %s", msg);
    mismatches++;
  endtask

  task automatic check_result();
    hex_result_t want;
    if (expected_results.size() == 0) begin
      report_mismatch($sformatf("unexpected result, status %0d addr %h", out_status,
                                out_record_address));
      return;
    end
    want = expected_results.pop_front();
    if (out_status !== want.st)
      report_mismatch($sformatf("status %0d, expected %0d", out_status, want.st));
    if (out_record_address !== want.addr)
      report_mismatch($sformatf("record_address %h, expected %h", out_record_address, want.addr));
    if (out_byte_index !== want.idx)
      report_mismatch($sformatf("byte_index %0d, expected %0d", out_byte_index, want.idx));
    if (out_data_byte !== want.data)
      report_mismatch($sformatf("data_byte %h, expected %h", out_data_byte, want.data));
    if (out_record_type !== want.rtype)
      report_mismatch($sformatf("record_type %h, expected %h", out_record_type, want.rtype));
    if (out_record_length !== want.rlen)
      report_mismatch($sformatf("record_length %h, expected %h", out_record_length, want.rlen));
    if (out_last !== want.last)
      report_mismatch($sformatf("last %b, expected %b", out_last, want.last));
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) parse_char(in_char_byte, in_restart);
      if (!in_valid || !in_stall) begin
        if (pending_chars.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          next_char = pending_chars.pop_front();
          in_char_byte <= next_char.ch;
          in_restart <= next_char.rs;
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) check_result();
      out_stall <= (hold_left != 0) || ($urandom_range(99) < stall_pct);
    end
  end

  always @(posedge clk) begin
    if (hold_go && !hold_done) begin
      hold_left <= 300;
      hold_done <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end
  end

  function automatic logic [7:0] hex_digit(logic [3:0] n);
    if (n < 10) return "0" + n;
    return 8'(($urandom_range(1) ? "a" : "A") + n - 10);
  endfunction

  function automatic logic [7:0] space_char();
    int r;
    r = $urandom_range(5);
    return (r == 5) ? " " : 8'(8'h09 + r);
  endfunction

  function automatic logic [7:0] pick_len();
    int r;
    r = $urandom_range(9);
    if (r == 0) return 8'd0;
    if (r == 1) return 8'(ihex_pkg::MAX_LEN);
    if (r == 2) return 8'($urandom_range(5, ihex_pkg::MAX_LEN));
    return 8'($urandom_range(1, 4));
  endfunction

  task automatic push_char(logic [7:0] c);
    pending_chars.push_back('{c, 1'b0});
  endtask

  task automatic push_text(string s);
    for (int i = 0; i < s.len(); i++) push_char(s[i]);
  endtask

  task automatic push_byte(logic [7:0] b);
    push_char(hex_digit(b[7:4]));
    push_char(hex_digit(b[3:0]));
  endtask

  task automatic maybe_space();
    if ($urandom_range(3) == 0) push_char(space_char());
  endtask

  task automatic push_restart();
    pending_chars.push_back('{8'($urandom), 1'b1});
  endtask

  task automatic queue_restart();
    if ($urandom_range(1)) repeat ($urandom_range(1, 3)) push_char(8'($urandom));
    push_restart();
  endtask

  task automatic queue_record(logic [7:0] len, logic [15:0] addr, logic [7:0] rtype,
                              logic good_sum);
    logic [7:0] sum;
    logic [7:0] b;
    push_char(ihex_pkg::COLON);
    maybe_space();
    push_byte(len);
    maybe_space();
    push_byte(addr[15:8]);
    push_byte(addr[7:0]);
    maybe_space();
    push_byte(rtype);
    maybe_space();
    sum = len + addr[15:8] + addr[7:0] + rtype;
    for (int i = 0; i < len; i++) begin
      b = 8'($urandom);
      sum = sum + b;
      push_byte(b);
      maybe_space();
    end
    sum = -sum;
    if (!good_sum) sum = sum + 8'($urandom_range(1, 255));
    push_byte(sum);
    maybe_space();
  endtask

  task automatic queue_broken();
    logic [7:0] c;
    push_char(ihex_pkg::COLON);
    push_byte(pick_len());
    repeat ($urandom_range(0, 3)) push_byte(8'($urandom));
    case ($urandom_range(2))
      0: begin
        push_char(hex_digit(4'($urandom)));
        push_char(space_char());
      end
      default: begin
        if ($urandom_range(1)) push_char(hex_digit(4'($urandom)));
        do c = 8'($urandom); while (nibble_of(c) >= 0 || is_blank(c));
        push_char(c);
      end
    endcase
  endtask

  task automatic queue_random(int n);
    int goal;
    int kind;
    goal = pending_chars.size() + n;
    while (pending_chars.size() < goal) begin
      kind = $urandom_range(99);
      if (kind < 55) begin
        queue_record(pick_len(), 16'($urandom), 8'h00, 1'b1);
      end else if (kind < 65) begin
        queue_record(pick_len(), 16'($urandom), 8'($urandom_range(1, 255)), 1'b1);
      end else if (kind < 73) begin
        queue_record(pick_len(), 16'($urandom), 8'($urandom_range(1)), 1'b0);
      end else if (kind < 80) begin
        push_char(ihex_pkg::COLON);
        push_byte(8'($urandom_range(ihex_pkg::MAX_LEN + 1, 255)));
        repeat (3) push_byte(8'($urandom));
      end else if (kind < 88) begin
        queue_broken();
      end else if (kind < 94) begin
        push_char(ihex_pkg::COLON);
        repeat ($urandom_range(0, 3)) push_byte(8'($urandom));
      end else begin
        push_char(8'($urandom));
      end
      if (kind >= 55) queue_restart();
    end
  endtask

  task automatic drain();
    while (pending_chars.size() != 0 || in_valid || expected_results.size() != 0)
      @(posedge clk);
  endtask

  initial begin
    halted = 1'b0;
    clear_record();
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    push_char("x");
    push_restart();
    push_text(":00FFFF0002");
    push_text(":1g");
    push_restart();
    push_text(":11000000");
    push_restart();
    queue_random(35);
    drain();

    send_idle_pct = 88;
    queue_random(35);
    drain();

    send_idle_pct = 0;
    stall_pct = 88;
    queue_random(35);
    drain();

    send_idle_pct = 27;
    stall_pct = 27;
    queue_random(35);
    drain();

    send_idle_pct = 0;
    stall_pct = 0;
    queue_record(8'(ihex_pkg::MAX_LEN), 16'($urandom), 8'h00, 1'b1);
    queue_random(10);
    @(posedge clk);
    hold_go <= 1'b1;
    drain();

    repeat (20) @(posedge clk);
    if (mismatches == 0) begin
      $display("** intel_hex_record_parser: PASSED **");
    end else begin
      $display("** intel_hex_record_parser: FAILED **");
    end
    $finish;
  end

  initial begin
    #400000;
    $display("** intel_hex_record_parser: FAILED **");
    $finish;
  end

endmodule

FILE: filelist.f
rtl/ihex_pkg.sv
rtl/ihex_ctrl.sv
rtl/ihex_dp.sv
rtl/intel_hex_record_parser.sv
tb/intel_hex_record_parser_tb.sv
